// File: hw/rtl/swept_circle_box_hit_time_core_macros.svh
// ----------------------------------------------------------------------------
// swept circle box hit time core assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef SWEPT_CIRCLE_BOX_HIT_TIME_CORE_MACROS_SVH
`define SWEPT_CIRCLE_BOX_HIT_TIME_CORE_MACROS_SVH

// same-cycle implication under reset
`define SWCB_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("swcb assertion failed");

// next-cycle implication under reset
`define SWCB_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("swcb assertion failed");

`endif

// File: hw/rtl/swcb_pkg.sv
// ----------------------------------------------------------------------------
// swcb_pkg
// shared constants, lane types and saturation helper
// ----------------------------------------------------------------------------
package swcb_pkg;

    localparam int FRAC_BITS = 16;
    // one quotient bit per cell, the top bit is done in the front end
    localparam int NCELL     = 2 * FRAC_BITS;
    localparam int QW        = 2 * FRAC_BITS + 1;
    localparam int TW        = 17;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;

    // per-axis data moving down the divider chain
    typedef struct packed {
        logic signed [31:0] off_lo;
        logic signed [31:0] off_hi;
        logic               zero;
        logic               zrej;
        logic               neg;
        logic [31:0]        dvs;
        logic [31:0]        rem;
        logic [QW-1:0]      quo;
    } lane_t;

    typedef struct packed {
        lane_t x;
        lane_t y;
        logic  in_box;
    } stage_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(S32_MAX))
            r = S32_MAX;
        else if (v < 64'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/swcb_if.sv
// ----------------------------------------------------------------------------
// swcb channel interfaces
// valid/ready channels for the query item and the result item
// ----------------------------------------------------------------------------
interface swcb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] end_x;
    logic [31:0] end_y;
    logic [30:0] circle_radius;
    logic [31:0] box_left;
    logic [31:0] box_top;
    logic [14:0] box_width;
    logic [14:0] box_height;

    modport source (output valid, start_x, start_y, end_x, end_y, circle_radius,
                    box_left, box_top, box_width, box_height, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, circle_radius,
                  box_left, box_top, box_width, box_height, output ready);
endinterface

interface swcb_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [16:0] hit_time;

    modport source (output valid, hit, hit_time, input ready);
    modport sink (input valid, hit, hit_time, output ready);
endinterface

// File: hw/rtl/swcb_div_cell.sv
// ----------------------------------------------------------------------------
// swcb_div_cell
// one restoring-division step per lane, registered, for the reciprocal chain
// ----------------------------------------------------------------------------
module swcb_div_cell
    import swcb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   valid_in,
    input  stage_t stage_in,
    output logic   valid_out,
    output stage_t stage_out
);

    logic   valid_reg;
    stage_t stage_reg;
    stage_t stage_next;

    function automatic lane_t step(input lane_t l);
        lane_t       o;
        logic [32:0] r2;
        o  = l;
        r2 = {l.rem, 1'b0};
        if (r2 >= {1'b0, l.dvs})
        begin
            o.rem = 32'(r2 - {1'b0, l.dvs});
            o.quo = {l.quo[QW-2:0], 1'b1};
        end
        else
        begin
            o.rem = r2[31:0];
            o.quo = {l.quo[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    // next quotient bit on both axes
    always_comb
    begin
        stage_next   = stage_in;
        stage_next.x = step(stage_in.x);
        stage_next.y = step(stage_in.y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            stage_reg <= stage_next;
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

// File: hw/rtl/swcb_front.sv
// ----------------------------------------------------------------------------
// swcb_front
// grows the box, forms motion and edge offsets, seeds the divider chain
// ----------------------------------------------------------------------------
module swcb_front
    import swcb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   valid_in,
    input  logic [31:0] start_x,
    input  logic [31:0] start_y,
    input  logic [31:0] end_x,
    input  logic [31:0] end_y,
    input  logic [30:0] circle_radius,
    input  logic [31:0] box_left,
    input  logic [31:0] box_top,
    input  logic [14:0] box_width,
    input  logic [14:0] box_height,
    output logic   valid_out,
    output stage_t stage_out
);

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] xmin;
        logic signed [31:0] xmax;
        logic signed [31:0] ymin;
        logic signed [31:0] ymax;
    } geo_t;

    logic   v1_reg;
    logic   v2_reg;
    geo_t   geo_reg;
    geo_t   geo_next;
    stage_t stage_reg;
    stage_t stage_next;

    // grown edges and motion, exact then clamped
    always_comb
    begin
        logic signed [63:0] r64;
        r64           = 64'(signed'({1'b0, circle_radius}));
        geo_next.sx   = signed'(start_x);
        geo_next.sy   = signed'(start_y);
        geo_next.dx   = sat32(64'(signed'(end_x)) - 64'(signed'(start_x)));
        geo_next.dy   = sat32(64'(signed'(end_y)) - 64'(signed'(start_y)));
        geo_next.xmin = sat32(64'(signed'(box_left)) - r64);
        geo_next.ymin = sat32(64'(signed'(box_top)) - r64);
        geo_next.xmax = sat32(64'(signed'(box_left)) + r64
                              + (64'(signed'({1'b0, box_width})) <<< FRAC_BITS));
        geo_next.ymax = sat32(64'(signed'(box_top)) + r64
                              + (64'(signed'({1'b0, box_height})) <<< FRAC_BITS));
    end

    function automatic lane_t seed(input logic signed [31:0] p0,
                                   input logic signed [31:0] d,
                                   input logic signed [31:0] lo,
                                   input logic signed [31:0] hi);
        lane_t l;
        l.off_lo = sat32(64'(lo) - 64'(p0));
        l.off_hi = sat32(64'(hi) - 64'(p0));
        l.zero   = (d == 32'sd0);
        l.zrej   = l.zero && (p0 < lo || p0 > hi);
        l.neg    = d[31];
        l.dvs    = d[31] ? 32'(-d) : 32'(d);
        // top quotient bit: the dividend is a single one bit
        l.rem    = (l.dvs == 32'd1) ? 32'd0 : 32'd1;
        l.quo    = QW'(l.dvs == 32'd1);
        return l;
    endfunction

    // slab offsets, start-in-box test and first division step
    always_comb
    begin
        stage_next.x      = seed(geo_reg.sx, geo_reg.dx, geo_reg.xmin, geo_reg.xmax);
        stage_next.y      = seed(geo_reg.sy, geo_reg.dy, geo_reg.ymin, geo_reg.ymax);
        stage_next.in_box = geo_reg.sx >= geo_reg.xmin && geo_reg.sx <= geo_reg.xmax
                         && geo_reg.sy >= geo_reg.ymin && geo_reg.sy <= geo_reg.ymax;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            geo_reg   <= geo_next;
            stage_reg <= stage_next;
        end
    end

    assign valid_out = v2_reg;
    assign stage_out = stage_reg;

endmodule

// File: hw/rtl/swcb_back.sv
// ----------------------------------------------------------------------------
// swcb_back
// signed reciprocal, slab times, interval merge and result register
// ----------------------------------------------------------------------------
module swcb_back
    import swcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        valid_in,
    input  stage_t      stage_in,
    output logic        valid_out,
    output logic        hit,
    output logic [16:0] hit_time
);

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               zero;
        logic               zrej;
    } ax_t;

    typedef struct packed {
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic               zero;
        logic               zrej;
    } px_t;

    logic [3:0] v_reg;
    ax_t  ix_reg, iy_reg, ix_next, iy_next;
    px_t  mx_reg, my_reg, mx_next, my_next;
    ax_t  tx_reg, ty_reg, tx_next, ty_next;
    logic in1_reg, in2_reg, in3_reg;
    logic        hit_reg, hit_next;
    logic [16:0] time_reg, time_next;

    // a = low-edge offset, b = high-edge offset
    function automatic ax_t recip(input lane_t l);
        ax_t o;
        o.a    = l.off_lo;
        o.b    = l.off_hi;
        o.zero = l.zero;
        o.zrej = l.zrej;
        return o;
    endfunction

    function automatic logic signed [31:0] inv_of(input lane_t l);
        logic signed [31:0] r;
        if (l.neg)
            r = (l.quo > QW'(64'h8000_0000)) ? S32_MIN : 32'(-l.quo);
        else
            r = (l.quo > QW'(64'h7fff_ffff)) ? S32_MAX : signed'(l.quo[31:0]);
        return r;
    endfunction

    logic signed [31:0] invx_reg, invy_reg;

    always_comb
    begin
        ix_next = recip(stage_in.x);
        iy_next = recip(stage_in.y);
    end

    // products of offsets and reciprocal
    always_comb
    begin
        mx_next.a    = 64'(ix_reg.a) * 64'(invx_reg);
        mx_next.b    = 64'(ix_reg.b) * 64'(invx_reg);
        mx_next.zero = ix_reg.zero;
        mx_next.zrej = ix_reg.zrej;
        my_next.a    = 64'(iy_reg.a) * 64'(invy_reg);
        my_next.b    = 64'(iy_reg.b) * 64'(invy_reg);
        my_next.zero = iy_reg.zero;
        my_next.zrej = iy_reg.zrej;
    end

    // per-axis entry and exit, clipped to 0..1; a still axis is neutral
    function automatic ax_t times(input px_t p);
        ax_t o;
        logic signed [31:0] t1, t2, lo, hi;
        t1 = sat32(p.a >>> FRAC_BITS);
        t2 = sat32(p.b >>> FRAC_BITS);
        lo = (t1 > t2) ? t2 : t1;
        hi = (t1 > t2) ? t1 : t2;
        o.zero = p.zero;
        o.zrej = p.zrej;
        if (p.zero)
        begin
            o.a = 32'sd0;
            o.b = ONE;
        end
        else
        begin
            o.a = (lo > 32'sd0) ? lo : 32'sd0;
            o.b = (hi < ONE) ? hi : ONE;
        end
        return o;
    endfunction

    always_comb
    begin
        tx_next = times(mx_reg);
        ty_next = times(my_reg);
    end

    // merge both axes into the result; a start inside the box hits at time zero
    always_comb
    begin
        logic signed [31:0] te, tq;
        te = (tx_reg.a > ty_reg.a) ? tx_reg.a : ty_reg.a;
        tq = (tx_reg.b < ty_reg.b) ? tx_reg.b : ty_reg.b;
        if (in3_reg)
        begin
            hit_next  = 1'b1;
            time_next = '0;
        end
        else if (!tx_reg.zrej && !ty_reg.zrej && te <= tq)
        begin
            hit_next  = 1'b1;
            time_next = te[16:0];
        end
        else
        begin
            hit_next  = 1'b0;
            time_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ix_reg   <= ix_next;
            iy_reg   <= iy_next;
            invx_reg <= inv_of(stage_in.x);
            invy_reg <= inv_of(stage_in.y);
            in1_reg  <= stage_in.in_box;
            mx_reg   <= mx_next;
            my_reg   <= my_next;
            in2_reg  <= in1_reg;
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
            in3_reg  <= in2_reg;
            hit_reg  <= hit_next;
            time_reg <= time_next;
        end
    end

    assign valid_out = v_reg[3];
    assign hit       = hit_reg;
    assign hit_time  = time_reg;

endmodule

// File: hw/rtl/swept_circle_box_hit_time_core.sv
// ----------------------------------------------------------------------------
// swept_circle_box_hit_time_core
// swept circle against axis-aligned box, entry time by slab test
// ----------------------------------------------------------------------------
// Takes one query item per clock while results flow and returns one result
// item per query, in order. The pipe is two front stages (grown box,
// offsets), a reciprocal chain of 32 division cells, each settling one
// quotient bit of 2^32 / motion for both axes, and then reciprocal, multiply,
// slab time and merge stages. The whole pipe advances whenever the result
// register is empty or being taken, so a new item enters every cycle while
// results flow.
module swept_circle_box_hit_time_core
    import swcb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    swcb_in_if.sink    pair,
    swcb_out_if.source result
);

    logic   adv;
    logic   fv;
    stage_t fs;
    logic   cv [0:NCELL];
    stage_t cs [0:NCELL];

    // global advance: result register free or drained this cycle
    assign adv        = !result.valid || result.ready;
    assign pair.ready = adv;

    swcb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .valid_in      (pair.valid),
        .start_x       (pair.start_x),
        .start_y       (pair.start_y),
        .end_x         (pair.end_x),
        .end_y         (pair.end_y),
        .circle_radius (pair.circle_radius),
        .box_left      (pair.box_left),
        .box_top       (pair.box_top),
        .box_width     (pair.box_width),
        .box_height    (pair.box_height),
        .valid_out     (fv),
        .stage_out     (fs)
    );

    assign cv[0] = fv;
    assign cs[0] = fs;

    // reciprocal chain
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        swcb_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (cv[i]),
            .stage_in  (cs[i]),
            .valid_out (cv[i+1]),
            .stage_out (cs[i+1])
        );
    end

    swcb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (cv[NCELL]),
        .stage_in  (cs[NCELL]),
        .valid_out (result.valid),
        .hit       (result.hit),
        .hit_time  (result.hit_time)
    );

endmodule

// File: hw/rtl/swcb_checker.sv
// ----------------------------------------------------------------------------
// swcb_checker
// port-level checks on the result channel, bound to the core
// ----------------------------------------------------------------------------
`include "swept_circle_box_hit_time_core_macros.svh"

module swcb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_hit,
    input logic [16:0] out_hit_time
);

    // a miss carries no time
    `SWCB_ASSERT_IMPLY(a_miss_zero, clk, rst_n, out_valid && !out_hit, out_hit_time == 17'd0)
    // entry time never beyond one
    `SWCB_ASSERT_IMPLY(a_time_range, clk, rst_n, out_valid && out_hit_time[16], out_hit_time[15:0] == 16'd0)
    // a stalled result holds its value
    `SWCB_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_hit_time))
    // input side stalls only behind a waiting result
    `SWCB_ASSERT_IMPLY(a_ready, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

bind swept_circle_box_hit_time_core swcb_checker u_swcb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (pair.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_hit      (result.hit),
    .out_hit_time (result.hit_time)
);

// File: verif/swept_circle_box_hit_time_core_tb.sv
// ----------------------------------------------------------------------------
// swept_circle_box_hit_time_core_tb
// drives swept-circle queries through the core and checks each result item
// against an in-bench fixed-point slab-test predictor, under varied idling
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module swept_circle_box_hit_time_core_tb;
    import swcb_pkg::*;

    typedef struct {
        logic [31:0] sx, sy, ex, ey;
        logic [30:0] rad;
        logic [31:0] bl, bt;
        logic [14:0] bw, bh;
    } query_t;

    typedef struct {
        logic        hit;
        logic [16:0] t;
    } hit_t;

    localparam longint QONE  = 64'sd1 <<< FRAC_BITS;
    localparam longint SMAX  = 64'sd2147483647;
    localparam longint SMIN  = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    swcb_in_if  pair_ch();
    swcb_out_if result_ch();

    swept_circle_box_hit_time_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch.sink),
        .result (result_ch.source)
    );

    always #10 clk = ~clk;

    query_t pending_q[$];
    hit_t   expected_hits[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_send = 1'b0;
    int     fail_count = 0;
    longint cycle_count = 0;

    function automatic longint clamp32(input longint v);
        longint r;
        r = v;
        if (v > SMAX)
            r = SMAX;
        else if (v < SMIN)
            r = SMIN;
        return r;
    endfunction

    // product shifted down with floor rounding, then clamped
    function automatic longint fix_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> FRAC_BITS);
    endfunction

    // one axis slab; narrows entry/exit, returns 0 on reject
    function automatic bit slab_pass(input longint p0, input longint p1, input longint lo,
                                     input longint hi, inout longint te, inout longint tx);
        longint d, inv, t1, t2, k;
        d = clamp32(p1 - p0);
        if (d == 0)
            return !(p0 < lo || p0 > hi);
        inv = clamp32((64'sd1 <<< (2 * FRAC_BITS)) / d);
        t1 = fix_mul(clamp32(lo - p0), inv);
        t2 = fix_mul(clamp32(hi - p0), inv);
        if (t1 > t2)
        begin
            k = t1;
            t1 = t2;
            t2 = k;
        end
        if (t1 > te)
            te = t1;
        if (t2 < tx)
            tx = t2;
        return !(te > tx);
    endfunction

    function automatic hit_t predict_hit(input query_t q);
        longint sx, sy, ex, ey, r, xmin, xmax, ymin, ymax, te, tx;
        hit_t   h;
        bit     ok;
        sx = longint'($signed(q.sx));
        sy = longint'($signed(q.sy));
        ex = longint'($signed(q.ex));
        ey = longint'($signed(q.ey));
        r  = longint'(q.rad);
        xmin = clamp32(longint'($signed(q.bl)) - r);
        ymin = clamp32(longint'($signed(q.bt)) - r);
        xmax = clamp32(longint'($signed(q.bl)) + (longint'(q.bw) <<< FRAC_BITS) + r);
        ymax = clamp32(longint'($signed(q.bt)) + (longint'(q.bh) <<< FRAC_BITS) + r);
        te = 0;
        tx = QONE;
        h.hit = 1'b0;
        h.t = '0;
        if (sx >= xmin && sx <= xmax && sy >= ymin && sy <= ymax)
        begin
            h.hit = 1'b1;
            return h;
        end
        ok = slab_pass(sx, ex, xmin, xmax, te, tx);
        if (ok)
            ok = slab_pass(sy, ey, ymin, ymax, te, tx);
        if (ok && te >= 0 && te <= QONE)
        begin
            h.hit = 1'b1;
            h.t = te[16:0];
        end
        return h;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        fail_count++;
    endtask

    // driver: presents the next queued item, holds it until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_ch.valid <= 1'b0;
        end
        else
        begin
            if (pair_ch.valid && pair_ch.ready)
                void'(pending_q.pop_front());
            if ((!pair_ch.valid || pair_ch.ready))
            begin
                // the item at the head is the next one to present
                if (pending_q.size() > 0 &&
                    !hold_send && $urandom_range(99) >= send_idle_pct)
                begin
                    query_t q;
                    q = pending_q[0];
                    pair_ch.valid <= 1'b1;
                    pair_ch.start_x <= q.sx;
                    pair_ch.start_y <= q.sy;
                    pair_ch.end_x <= q.ex;
                    pair_ch.end_y <= q.ey;
                    pair_ch.circle_radius <= q.rad;
                    pair_ch.box_left <= q.bl;
                    pair_ch.box_top <= q.bt;
                    pair_ch.box_width <= q.bw;
                    pair_ch.box_height <= q.bh;
                    expected_hits.push_back(predict_hit(q));
                end
                else
                    pair_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: takes result items and compares with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_hits.size() == 0)
                    report_mismatch("unexpected item", 1, 0);
                else
                begin
                    hit_t w;
                    w = expected_hits.pop_front();
                    if (result_ch.hit !== w.hit)
                        report_mismatch("hit", result_ch.hit, w.hit);
                    if (result_ch.hit_time !== w.t)
                        report_mismatch("hit_time", result_ch.hit_time, w.t);
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        pair_ch.start_x = '0;
        pair_ch.start_y = '0;
        pair_ch.end_x = '0;
        pair_ch.end_y = '0;
        pair_ch.circle_radius = '0;
        pair_ch.box_left = '0;
        pair_ch.box_top = '0;
        pair_ch.box_width = '0;
        pair_ch.box_height = '0;
    end

    function automatic query_t make_query(input logic [31:0] sx, sy, ex, ey,
                                          input logic [30:0] rad, input logic [31:0] bl, bt,
                                          input logic [14:0] bw, bh);
        query_t q;
        q.sx = sx; q.sy = sy; q.ex = ex; q.ey = ey; q.rad = rad;
        q.bl = bl; q.bt = bt; q.bw = bw; q.bh = bh;
        return q;
    endfunction

    // random query: a scene near the box at small or large scale, sometimes raw noise
    function automatic query_t random_query();
        query_t q;
        int     mode;
        logic signed [31:0] bl, bt, span;
        mode = $urandom_range(9);
        if (mode < 2)
            return make_query($urandom, $urandom, $urandom, $urandom, 31'($urandom),
                              $urandom, $urandom, 15'($urandom), 15'($urandom));
        span = (mode < 5) ? 32'sh0040_0000 : 32'sh4000_0000;
        bl = $signed($urandom) % span;
        bt = $signed($urandom) % span;
        q.bl = bl;
        q.bt = bt;
        q.bw = 15'($urandom_range(mode == 9 ? 32767 : 40));
        q.bh = 15'($urandom_range(mode == 9 ? 32767 : 40));
        q.rad = 31'($urandom_range(0, 32'h0008_0000));
        q.sx = bl + ($signed($urandom) % span);
        q.sy = bt + ($signed($urandom) % span);
        q.ex = ($urandom_range(7) == 0) ? q.sx : bl + ($signed($urandom) % span);
        q.ey = ($urandom_range(7) == 0) ? q.sy : bt + ($signed($urandom) % span);
        return q;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() != 0 || expected_hits.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: inside, edges, zero motion, saturation, late entry
        pending_q.push_back(make_query(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                       32'h0001_0000, 0, 0, 0, 2, 2));
        pending_q.push_back(make_query(32'hfffe_0000, 32'h0001_0000, 32'h0005_0000,
                                       32'h0001_0000, 31'h0000_8000, 0, 0, 2, 2));
        pending_q.push_back(make_query(32'hfffe_0000, 32'h0009_0000, 32'hfffe_0000,
                                       32'h0001_0000, 0, 0, 0, 2, 2));
        pending_q.push_back(make_query(32'hfffe_0000, 32'h0009_0000, 32'hfff0_0000,
                                       32'h0009_0000, 0, 0, 0, 2, 2));
        pending_q.push_back(make_query(32'hfff0_0000, 32'h0001_0000, 32'hfff1_0000,
                                       32'h0001_0000, 0, 0, 0, 2, 2));
        pending_q.push_back(make_query(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                       32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff,
                                       32'h7fff_ffff, 15'h7fff, 15'h7fff));
        pending_q.push_back(make_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                       32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000,
                                       0, 0));
        pending_q.push_back(make_query(32'h8000_0000, 0, 32'h7fff_ffff, 0, 0, 0,
                                       32'h7fff_ffff, 15'h7fff, 0));
        pending_q.push_back(make_query(32'hffff_0000, 0, 32'h0000_0001, 0, 0,
                                       0, 0, 1, 1));
        pending_q.push_back(make_query(32'h0002_0000, 0, 32'h0000_0000, 0, 0,
                                       0, 0, 1, 1));
        pending_q.push_back(make_query(0, 0, 0, 0, 0, 32'h0000_0001, 0, 0, 0));
        pending_q.push_back(make_query(32'hffff_ffff, 32'hffff_ffff, 1, 1, 0, 0, 0, 0, 0));
        for (int i = 0; i < 10; i++)
            pending_q.push_back(random_query());
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 68 : 25) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 68 : 25) : 0;
            for (int i = 0; i < 310; i++)
                pending_q.push_back(random_query());
            if (ph == 1)
            begin
                // hold the sender until every result is back
                while (pending_q.size() > 150)
                    @(posedge clk);
                hold_send = 1'b1;
                while (expected_hits.size() != 0)
                    @(posedge clk);
                hold_send = 1'b0;
            end
            wait_drained();
        end
        repeat (60) @(posedge clk);

        if (fail_count == 0)
            $display("swept_circle_box_hit_time_core test passed");
        else
            $display("swept_circle_box_hit_time_core test failed");
        $finish;
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycle_count > 400000)
        begin
            $display("swept_circle_box_hit_time_core test failed");
            $finish;
        end
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/swcb_pkg.sv
hw/rtl/swcb_if.sv
hw/rtl/swcb_div_cell.sv
hw/rtl/swcb_front.sv
hw/rtl/swcb_back.sv
hw/rtl/swept_circle_box_hit_time_core.sv
hw/rtl/swcb_checker.sv
verif/swept_circle_box_hit_time_core_tb.sv
